// ===== hw/rtl/box_region_fault_detector_core_defines.svh =====
// Assertion macros shared by the box region fault detector checker.
// Depends on nothing; included by the checker file.
`ifndef BOX_REGION_FAULT_DETECTOR_CORE_DEFINES_SVH
`define BOX_REGION_FAULT_DETECTOR_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define BRFD_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("box region fault detector check failed");
// Next-cycle implication checked outside reset.
`define BRFD_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("box region fault detector check failed");
`endif

// ===== hw/rtl/brfd_pkg.sv =====
// Shared types, constants and controller commands for the box region fault detector.
// Depends on nothing.
package brfd_pkg;
  localparam int CheckCountDef  = 16;
  localparam int RegionCountDef = 16;
  localparam int DimensionsDef  = 8;
  localparam int CoordW = 32;
  localparam int CountW = 4;
  localparam int ScoreW = 65;
  localparam logic [63:0] SatMax = 64'h7fff_ffff_ffff_ffff;

  localparam logic [3:0] CMD_IDLE   = 4'd0;
  localparam logic [3:0] CMD_LOAD   = 4'd1;
  localparam logic [3:0] CMD_TREAD  = 4'd2;
  localparam logic [3:0] CMD_TCMP   = 4'd3;
  localparam logic [3:0] CMD_APPEND = 4'd4;
  localparam logic [3:0] CMD_PREAD  = 4'd5;
  localparam logic [3:0] CMD_PSTEP  = 4'd6;
  localparam logic [3:0] CMD_PSAVE  = 4'd7;
  localparam logic [3:0] CMD_MREAD  = 4'd8;
  localparam logic [3:0] CMD_MWRITE = 4'd9;
  localparam logic [3:0] CMD_LREAD  = 4'd10;
  localparam logic [3:0] CMD_LWRITE = 4'd11;
  localparam logic [3:0] CMD_DONE   = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [5:0] ia;
    logic [5:0] ib;
    logic [2:0] dim;
  } ctl_cmd_t;

  typedef struct packed {
    logic       op_train;
    logic       bad;
    logic       id_ok;
    logic [6:0] count;
    logic       hit;
  } ctl_stat_t;
endpackage

// ===== hw/rtl/box_region_fault_detector_core.sv =====
// Top level of the box region fault detector: per-check box tables with fault test.
// Depends on brfd_pkg, brfd_ctrl and brfd_datapath.
// Usage: raise start with the request fields while busy is low; the request is
// taken at that edge and busy rises the next cycle. One result follows: done is
// high for exactly one cycle with fault and regions_used; the receiver cannot
// stall, so it must sample the result in that cycle.
// Sequence: a test reads and compares each held box one dimension at a time,
// stopping at the last held box. A train that appends writes the new box one
// dimension at a time; a train that fills the table also scores every pair
// through the shared scoring unit, then merges the best pair and moves the
// last box into the freed slot. Out-of-range requests, invalid trains and tests
// on an empty table go straight to done. One request at a time.
// Reset clears every box count at once; box memories need no clearing, since
// only boxes below the count are read.
module box_region_fault_detector_core #(
  parameter int CHECK_COUNT  = brfd_pkg::CheckCountDef,
  parameter int REGION_COUNT = brfd_pkg::RegionCountDef,
  parameter int DIMENSIONS   = brfd_pkg::DimensionsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [3:0]  check_id,
  input  logic        value_invalid,
  input  logic signed [31:0] coord_0,
  input  logic signed [31:0] coord_1,
  input  logic signed [31:0] coord_2,
  input  logic signed [31:0] coord_3,
  input  logic signed [31:0] coord_4,
  input  logic signed [31:0] coord_5,
  input  logic signed [31:0] coord_6,
  input  logic signed [31:0] coord_7,
  output logic        done,
  output logic        fault,
  output logic [3:0]  regions_used
);
  brfd_pkg::ctl_cmd_t  cmd;
  brfd_pkg::ctl_stat_t stat;
  logic [5:0] best_i, best_k;
  logic start_load, done_c;

  brfd_ctrl #(.REGION_COUNT(REGION_COUNT), .DIMENSIONS(DIMENSIONS)) u_ctrl (
    .clk, .rst, .start, .busy, .start_load, .done(done_c), .stat, .best_i, .best_k, .cmd
  );

  brfd_datapath #(.CHECK_COUNT(CHECK_COUNT), .REGION_COUNT(REGION_COUNT),
                  .DIMENSIONS(DIMENSIONS)) u_dp (
    .clk, .rst, .start_load, .operation, .check_id, .value_invalid,
    .coords({coord_7, coord_6, coord_5, coord_4, coord_3, coord_2, coord_1, coord_0}),
    .cmd, .stat, .best_i, .best_k, .fault, .regions_used
  );

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= done_c;
  end
endmodule

// ===== hw/rtl/brfd_datapath.sv =====
// Box tables, containment test, pair scoring and merge arithmetic.
// Depends on brfd_pkg; driven by brfd_ctrl commands.
module brfd_datapath #(
  parameter int CHECK_COUNT  = brfd_pkg::CheckCountDef,
  parameter int REGION_COUNT = brfd_pkg::RegionCountDef,
  parameter int DIMENSIONS   = brfd_pkg::DimensionsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start_load,
  input  logic                operation,
  input  logic [3:0]          check_id,
  input  logic                value_invalid,
  input  logic [8*32-1:0]     coords,
  input  brfd_pkg::ctl_cmd_t  cmd,
  output brfd_pkg::ctl_stat_t stat,
  output logic [5:0]          best_i,
  output logic [5:0]          best_k,
  output logic                fault,
  output logic [3:0]          regions_used
);
  localparam int CW = (CHECK_COUNT > 1) ? $clog2(CHECK_COUNT) : 1;
  localparam int RW = $clog2(REGION_COUNT);
  localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int NW = $clog2(REGION_COUNT + 1);
  localparam int AW = CW + RW + DW;
  localparam int Depth = CHECK_COUNT * (2 ** (RW + DW));

  logic signed [31:0] mem_low  [Depth];
  logic signed [31:0] mem_high [Depth];
  logic signed [31:0] mem_mid  [Depth];
  logic [NW-1:0] cnt [CHECK_COUNT];

  logic          op_r, bad_r, ok_r;
  logic [CW-1:0] cid;
  logic [8*32-1:0] vec;
  logic signed [31:0] ra_low, ra_high, ra_mid, rb_low, rb_high, rb_mid;
  logic          hit, box_in;
  logic [63:0]   vol, dacc;
  logic          have;
  logic signed [64:0] best;
  logic signed [31:0] new_low, new_high;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] c, input logic [5:0] r,
                                         input logic [2:0] d);
    addr = {c, r[RW-1:0], d[DW-1:0]};
  endfunction

  logic [AW-1:0] addr_a, addr_b;
  logic [31:0]   vj;
  assign addr_a = addr(cid, cmd.ia, cmd.dim);
  assign addr_b = addr(cid, cmd.ib, cmd.dim);
  assign vj = vec[32*cmd.dim +: 32];

  logic signed [32:0] ov, dc;
  logic [31:0]  ad;
  logic [63:0]  sq_w;
  logic [63:0]  sq, dist_n;
  logic [64:0]  dsum;
  logic [63:0]  vp_hi, vp_lo;
  logic [95:0]  vprod;
  logic [63:0]  vol_n;
  logic signed [64:0] score;
  logic signed [32:0] msum;
  always_comb begin
    dc = $signed({ra_mid[31], ra_mid}) - $signed({rb_mid[31], rb_mid});
    ad = dc[32] ? 32'(-dc) : dc[31:0];
    sq_w = 64'(ad) * 64'(ad);
    sq = (sq_w > brfd_pkg::SatMax) ? brfd_pkg::SatMax : sq_w;
    dsum = 65'(dacc) + 65'(sq);
    dist_n = (dsum > 65'(brfd_pkg::SatMax)) ? brfd_pkg::SatMax : dsum[63:0];
    if (ra_low < rb_low) ov = $signed({ra_high[31], ra_high}) - $signed({rb_low[31], rb_low});
    else ov = $signed({rb_high[31], rb_high}) - $signed({ra_low[31], ra_low});
    vp_hi = 64'(vol[63:32]) * 64'(ov[31:0]);
    vp_lo = 64'(vol[31:0]) * 64'(ov[31:0]);
    vprod = {vp_hi, 32'd0} + 96'(vp_lo);
    if (ov <= 0) vol_n = 64'd0;
    else if (vprod > 96'(brfd_pkg::SatMax)) vol_n = brfd_pkg::SatMax;
    else vol_n = vprod[63:0];
    score = (vol != 64'd0) ? $signed({1'b0, vol}) : -$signed({1'b0, dacc});
    new_low  = (rb_low < ra_low) ? rb_low : ra_low;
    new_high = (rb_high > ra_high) ? rb_high : ra_high;
    msum = $signed({new_high[31], new_high}) + $signed({new_low[31], new_low});
  end

  always_ff @(posedge clk) begin
    if (start_load) begin
      op_r  <= operation;
      bad_r <= value_invalid;
      ok_r  <= (32'(check_id) < CHECK_COUNT);
      cid   <= CW'(check_id);
      vec   <= coords;
    end
    ra_low  <= mem_low[addr_a];
    ra_high <= mem_high[addr_a];
    ra_mid  <= mem_mid[addr_a];
    rb_low  <= mem_low[addr_b];
    rb_high <= mem_high[addr_b];
    rb_mid  <= mem_mid[addr_b];
    unique case (cmd.op)
      brfd_pkg::CMD_APPEND: begin
        mem_low[addr_a]  <= vj;
        mem_high[addr_a] <= vj;
        mem_mid[addr_a]  <= vj;
      end
      brfd_pkg::CMD_MWRITE: begin
        mem_low[addr_a]  <= new_low;
        mem_high[addr_a] <= new_high;
        mem_mid[addr_a]  <= msum[32:1];
      end
      brfd_pkg::CMD_LWRITE: begin
        mem_low[addr_b]  <= ra_low;
        mem_high[addr_b] <= ra_high;
        mem_mid[addr_b]  <= ra_mid;
      end
      default: ;
    endcase
  end

  assign box_in = (ra_low <= $signed(vec[32*cmd.dim +: 32]))
               && (ra_high >= $signed(vec[32*cmd.dim +: 32]));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHECK_COUNT; c++) cnt[c] <= '0;
      hit <= 1'b0; have <= 1'b0; fault <= 1'b0; regions_used <= '0;
      vol <= 64'd1; dacc <= '0; best <= '0; best_i <= '0; best_k <= '0;
    end else begin
      unique case (cmd.op)
        brfd_pkg::CMD_LOAD: begin
          hit <= 1'b0; have <= 1'b0;
        end
        brfd_pkg::CMD_TREAD: begin
          vol <= 64'd1;
        end
        brfd_pkg::CMD_TCMP: begin
          if (!box_in) vol <= 64'd0;
          if (cmd.ib[0] && (box_in && vol != 64'd0)) hit <= 1'b1;
        end
        brfd_pkg::CMD_APPEND: begin
          if (cmd.ib[0]) cnt[cid] <= cnt[cid] + NW'(1);
        end
        brfd_pkg::CMD_PREAD: begin
          vol <= 64'd1; dacc <= '0;
        end
        brfd_pkg::CMD_PSTEP: begin
          vol <= vol_n; dacc <= dist_n;
        end
        brfd_pkg::CMD_PSAVE: begin
          if (!have || score > best) begin
            best <= score; best_i <= cmd.ia; best_k <= cmd.ib; have <= 1'b1;
          end
        end
        brfd_pkg::CMD_LWRITE: begin
          if (cmd.dim == 3'(DIMENSIONS - 1))
            cnt[cid] <= cnt[cid] - NW'(1);
        end
        brfd_pkg::CMD_DONE: begin
          fault <= ok_r ? (!op_r && (bad_r || !hit)) : !op_r;
          regions_used <= ok_r ? 4'(cnt[cid]) : 4'd0;
        end
        default: ;
      endcase
    end
  end

  assign stat.op_train = op_r;
  assign stat.bad      = bad_r;
  assign stat.id_ok    = ok_r;
  assign stat.count    = 7'(cnt[cid]);
  assign stat.hit      = hit;
endmodule

// ===== hw/rtl/brfd_ctrl.sv =====
// Sequencer for test scans, appends, pair scoring and merges.
// Depends on brfd_pkg; commands brfd_datapath.
module brfd_ctrl #(
  parameter int REGION_COUNT = brfd_pkg::RegionCountDef,
  parameter int DIMENSIONS   = brfd_pkg::DimensionsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                start_load,
  output logic                done,
  input  brfd_pkg::ctl_stat_t stat,
  input  logic [5:0]          best_i,
  input  logic [5:0]          best_k,
  output brfd_pkg::ctl_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_TRD = 4'd2, S_TCMP = 4'd3,
    S_APP = 4'd4, S_PRD = 4'd5, S_PST = 4'd6, S_PSV = 4'd7, S_MRD = 4'd8,
    S_MWR = 4'd9, S_LRD = 4'd10, S_LWR = 4'd11, S_DONE = 4'd12;
  localparam logic [2:0] DLast = 3'(DIMENSIONS - 1);

  logic [3:0] state, state_next;
  logic [5:0] ia, ib, ia_next, ib_next;
  logic [2:0] dim, dim_next;
  logic [6:0] n;
  assign n = stat.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ia <= '0; ib <= '0; dim <= '0;
    end else begin
      state <= state_next; ia <= ia_next; ib <= ib_next; dim <= dim_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign start_load = (state == S_IDLE) && start;
  assign done = (state == S_DONE);

  always_comb begin
    state_next = state; ia_next = ia; ib_next = ib; dim_next = dim;
    cmd = '{op: brfd_pkg::CMD_IDLE, ia: ia, ib: ib, dim: dim};
    unique case (state)
      S_IDLE: if (start) begin
        state_next = S_DISP; cmd.op = brfd_pkg::CMD_LOAD;
      end
      S_DISP: begin
        ia_next = '0; dim_next = '0;
        if (!stat.id_ok) state_next = S_DONE;
        else if (!stat.op_train) state_next = (n == 7'd0) ? S_DONE : S_TRD;
        else if (stat.bad) state_next = S_DONE;
        else begin ia_next = 6'(n); state_next = S_APP; end
      end
      S_TRD: begin
        cmd.op = (dim == 3'd0) ? brfd_pkg::CMD_TREAD : brfd_pkg::CMD_IDLE;
        if (dim == 3'd0) cmd.op = brfd_pkg::CMD_TREAD;
        state_next = S_TCMP;
      end
      S_TCMP: begin
        cmd.op = brfd_pkg::CMD_TCMP; cmd.ib = {5'd0, dim == DLast};
        if (dim == DLast) begin
          dim_next = '0;
          if (7'(ia) + 7'd1 >= n) state_next = S_DONE;
          else begin ia_next = ia + 6'd1; state_next = S_TRD; end
        end else begin
          dim_next = dim + 3'd1; state_next = S_TRD;
        end
      end
      S_APP: begin
        cmd.op = brfd_pkg::CMD_APPEND; cmd.ib = {5'd0, dim == DLast};
        if (dim == DLast) begin
          dim_next = '0; ia_next = '0; ib_next = 6'd1;
          state_next = (7'(ia) + 7'd1 == 7'(REGION_COUNT)) ? S_PRD : S_DONE;
        end else dim_next = dim + 3'd1;
      end
      S_PRD: begin
        if (dim == 3'd0) cmd.op = brfd_pkg::CMD_PREAD;
        state_next = S_PST;
      end
      S_PST: begin
        cmd.op = brfd_pkg::CMD_PSTEP;
        if (dim == DLast) begin dim_next = '0; state_next = S_PSV; end
        else begin dim_next = dim + 3'd1; state_next = S_PRD; end
      end
      S_PSV: begin
        cmd.op = brfd_pkg::CMD_PSAVE;
        if (7'(ib) + 7'd1 < n) ib_next = ib + 6'd1;
        else if (7'(ia) + 7'd2 < n) begin ia_next = ia + 6'd1; ib_next = ia + 6'd2; end
        else begin ia_next = best_i; ib_next = best_k; end
        state_next = ((7'(ib) + 7'd1 < n) || (7'(ia) + 7'd2 < n)) ? S_PRD : S_MRD;
      end
      S_MRD: begin
        ia_next = best_i; ib_next = best_k;
        cmd.ia = best_i; cmd.ib = best_k; state_next = S_MWR;
      end
      S_MWR: begin
        cmd.op = brfd_pkg::CMD_MWRITE;
        if (dim == DLast) begin
          dim_next = '0; ia_next = 6'(n - 7'd1); state_next = S_LRD;
        end else begin dim_next = dim + 3'd1; state_next = S_MRD; end
      end
      S_LRD: state_next = S_LWR;
      S_LWR: begin
        cmd.op = brfd_pkg::CMD_LWRITE;
        if (dim == DLast) begin dim_next = '0; state_next = S_DONE; end
        else begin dim_next = dim + 3'd1; state_next = S_LRD; end
      end
      S_DONE: begin
        cmd.op = brfd_pkg::CMD_DONE; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/brfd_checker.sv =====
// Port-level checker for the box region fault detector, bound to the top level.
// Depends on box_region_fault_detector_core_defines.svh.
`include "box_region_fault_detector_core_defines.svh"
module brfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       fault
);
  `BRFD_ASSERT_NXT(a_take, clk, rst, start && !busy, busy)
  `BRFD_ASSERT_IMP(a_done_busy, clk, rst, done, !busy)
  `BRFD_ASSERT_NXT(a_done_once, clk, rst, done, !done)
  `BRFD_ASSERT_IMP(a_idle_quiet, clk, rst, !busy && !$past(busy), !done)
  `BRFD_ASSERT_IMP(a_fault_hold, clk, rst, !done, $stable(fault))
endmodule

bind box_region_fault_detector_core brfd_checker u_brfd_checker (
  .clk, .rst, .start, .busy, .done, .fault
);

// ===== tb/box_region_fault_detector_core_tb.sv =====
// Self-checking testbench for box_region_fault_detector_core: directed table, then random
// requests, checked against a box-table predictor. Depends on brfd_pkg and the core RTL.
module box_region_fault_detector_core_tb;
  localparam int NCHK = 16;
  localparam int NREG = 16;
  localparam int NDIM = 8;
  localparam int RANDOM_REQUESTS = 1600;
  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_TRAIN = 1'b1;

  typedef logic signed [brfd_pkg::CoordW-1:0] coord_t;
  typedef struct packed {
    logic             fault;
    logic [brfd_pkg::CountW-1:0] used;
  } verdict_t;
  typedef struct {
    logic   op;
    int     id;
    logic   bad;
    coord_t cv;
    bit     typed;
    verdict_t want;
  } row_t;

  logic clk, rst, start, busy, operation, value_invalid, done, fault;
  logic [3:0] check_id, regions_used;
  coord_t coord [NDIM];

  box_region_fault_detector_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .check_id(check_id), .value_invalid(value_invalid),
    .coord_0(coord[0]), .coord_1(coord[1]), .coord_2(coord[2]), .coord_3(coord[3]),
    .coord_4(coord[4]), .coord_5(coord[5]), .coord_6(coord[6]), .coord_7(coord[7]),
    .done(done), .fault(fault), .regions_used(regions_used)
  );

  coord_t box_lo [NCHK][NREG][NDIM];
  coord_t box_hi [NCHK][NREG][NDIM];
  coord_t box_ct [NCHK][NREG][NDIM];
  int     box_n  [NCHK];
  verdict_t verdict_q [$];
  bit       pend_typed;
  verdict_t pend_want;
  int errors, n_test, n_train, n_fault, n_merge;
  row_t rows [28];

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic logic signed [64:0] pair_score(int c, int i, int k);
    logic [127:0] vol, dsq, sq;
    logic signed [63:0] dc, ov;
    vol = 1;
    dsq = 0;
    for (int j = 0; j < NDIM; j++) begin
      dc = 64'(box_ct[c][i][j]) - 64'(box_ct[c][k][j]);
      if (dc < 0) dc = -dc;
      sq = 128'(dc) * 128'(dc);
      if (sq > brfd_pkg::SatMax) sq = brfd_pkg::SatMax;
      dsq = dsq + sq;
      if (dsq > brfd_pkg::SatMax) dsq = brfd_pkg::SatMax;
      if (box_lo[c][i][j] < box_lo[c][k][j]) ov = 64'(box_hi[c][i][j]) - 64'(box_lo[c][k][j]);
      else ov = 64'(box_hi[c][k][j]) - 64'(box_lo[c][i][j]);
      if (ov <= 0) vol = 0;
      else begin
        vol = vol * 128'(ov);
        if (vol > brfd_pkg::SatMax) vol = brfd_pkg::SatMax;
      end
    end
    if (vol > 0) return $signed({1'b0, vol[63:0]});
    return -$signed({1'b0, dsq[63:0]});
  endfunction

  function automatic void merge_best(int c);
    int n, bi, bk;
    logic signed [64:0] best, s;
    logic signed [32:0] sum;
    n = box_n[c];
    bi = 0;
    bk = 1;
    best = pair_score(c, 0, 1);
    for (int i = 0; i + 1 < n; i++)
      for (int k = i + 1; k < n; k++) begin
        s = pair_score(c, i, k);
        if (s > best) begin
          best = s; bi = i; bk = k;
        end
      end
    for (int j = 0; j < NDIM; j++) begin
      if (box_lo[c][bk][j] < box_lo[c][bi][j]) box_lo[c][bi][j] = box_lo[c][bk][j];
      if (box_hi[c][bk][j] > box_hi[c][bi][j]) box_hi[c][bi][j] = box_hi[c][bk][j];
      sum = 33'(box_hi[c][bi][j]) + 33'(box_lo[c][bi][j]);
      box_ct[c][bi][j] = coord_t'(sum >>> 1);
    end
    for (int j = 0; j < NDIM; j++) begin
      box_lo[c][bk][j] = box_lo[c][n-1][j];
      box_hi[c][bk][j] = box_hi[c][n-1][j];
      box_ct[c][bk][j] = box_ct[c][n-1][j];
    end
    box_n[c] = n - 1;
    n_merge++;
  endfunction

  function automatic verdict_t apply_request(logic op, int c, logic bad, coord_t v [NDIM]);
    verdict_t r;
    bit hit, in_box;
    r.fault = 1'b0;
    if (op == OP_TEST) begin
      hit = 0;
      for (int i = 0; i < box_n[c]; i++) begin
        in_box = 1;
        for (int j = 0; j < NDIM; j++)
          if (!(box_lo[c][i][j] <= v[j] && box_hi[c][i][j] >= v[j])) in_box = 0;
        if (in_box) hit = 1;
      end
      r.fault = bad || !hit;
    end else if (!bad && box_n[c] < NREG) begin
      for (int j = 0; j < NDIM; j++) begin
        box_lo[c][box_n[c]][j] = v[j];
        box_hi[c][box_n[c]][j] = v[j];
        box_ct[c][box_n[c]][j] = v[j];
      end
      box_n[c]++;
      if (box_n[c] == NREG) merge_best(c);
    end
    r.used = box_n[c][3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst) begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (fault !== want.fault) begin
            $error("fault: expected %0b actual %0b", want.fault, fault);
            errors++;
          end
          if (regions_used !== want.used) begin
            $error("regions_used: expected %0d actual %0d", want.used, regions_used);
            errors++;
          end
          if (fault === 1'b1) n_fault++;
        end
      end
      if (start && !busy) begin
        got = apply_request(operation, int'(check_id), value_invalid, coord);
        if (operation == OP_TEST) n_test++;
        else n_train++;
        if (pend_typed && got !== pend_want) begin
          $error("predictor disagrees with table row: %0h vs %0h", got, pend_want);
          errors++;
        end
        verdict_q.push_back(pend_typed ? pend_want : got);
      end
    end
  end

  int burst_left;

  task automatic send(logic op, int id, logic bad, coord_t v [NDIM], bit typed, verdict_t want);
    operation <= op;
    check_id <= id[3:0];
    value_invalid <= bad;
    for (int j = 0; j < NDIM; j++) coord[j] <= v[j];
    pend_typed <= typed;
    pend_want <= want;
    start <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    if (burst_left > 0) burst_left--;
    else begin
      start <= 1'b0;
      burst_left = $urandom_range(0, 12);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic coord_t pick_coord(int c, int j);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    if (sel < 16) return coord_t'($urandom);
    return coord_t'((c * 3 + j) * 32'sh0001_0000 + $urandom_range(0, 8 * 65536) - 4 * 65536);
  endfunction

  initial begin
    coord_t v [NDIM];
    verdict_t w;
    int c, b, sel, waited;
    logic [63:0] span;
    logic op, bad;
    rst = 1'b1;
    start = 1'b0;
    operation = 1'b0;
    check_id = 4'd0;
    value_invalid = 1'b0;
    pend_typed = 1'b0;
    pend_want = '0;
    for (int j = 0; j < NDIM; j++) coord[j] = '0;
    for (int i = 0; i < NCHK; i++) box_n[i] = 0;
    errors = 0;
    burst_left = 0;
    rows[0]  = '{OP_TEST,  0, 1'b0, 32'sh0, 1, '{1'b1, 4'd0}};
    rows[1]  = '{OP_TEST, 15, 1'b1, 32'sh0, 1, '{1'b1, 4'd0}};
    rows[2]  = '{OP_TRAIN, 0, 1'b1, 32'sh0, 1, '{1'b0, 4'd0}};
    rows[3]  = '{OP_TRAIN, 0, 1'b0, 32'sh0, 1, '{1'b0, 4'd1}};
    rows[4]  = '{OP_TEST,  0, 1'b0, 32'sh0, 1, '{1'b0, 4'd1}};
    rows[5]  = '{OP_TEST,  0, 1'b0, 32'sh1, 1, '{1'b1, 4'd1}};
    rows[6]  = '{OP_TRAIN, 0, 1'b0, 32'sh7fffffff, 1, '{1'b0, 4'd2}};
    rows[7]  = '{OP_TRAIN, 0, 1'b0, 32'sh80000000, 1, '{1'b0, 4'd3}};
    rows[8]  = '{OP_TEST,  0, 1'b0, 32'sh7fffffff, 1, '{1'b0, 4'd3}};
    rows[9]  = '{OP_TEST,  0, 1'b1, 32'sh80000000, 1, '{1'b1, 4'd3}};
    rows[10] = '{OP_TEST,  0, 1'b0, 32'sh8000, 1, '{1'b1, 4'd3}};
    for (int i = 0; i < NREG; i++)
      rows[11 + i] = '{OP_TRAIN, 5, 1'b0, coord_t'(i * 65536), 1,
                       '{1'b0, 4'((i + 1 < NREG) ? i + 1 : NREG - 1)}};
    rows[27] = '{OP_TEST, 5, 1'b0, 32'sh8000, 0, '{1'b0, 4'd0}};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r]) begin
      for (int j = 0; j < NDIM; j++) v[j] = rows[r].cv;
      send(rows[r].op, rows[r].id, rows[r].bad, v, rows[r].typed, rows[r].want);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      sel = $urandom_range(0, 99);
      c = (sel < 85) ? $urandom_range(0, 3) : $urandom_range(0, NCHK - 1);
      op = ($urandom_range(0, 99) < 35) ? OP_TRAIN : OP_TEST;
      bad = ($urandom_range(0, 99) < 7);
      for (int j = 0; j < NDIM; j++) v[j] = pick_coord(c, j);
      if (op == OP_TEST && box_n[c] > 0 && $urandom_range(0, 99) < 55) begin
        b = $urandom_range(0, box_n[c] - 1);
        for (int j = 0; j < NDIM; j++) begin
          span = 64'(65'(box_hi[c][b][j]) - 65'(box_lo[c][b][j])) + 1;
          case ($urandom_range(0, 3))
            0: v[j] = box_lo[c][b][j];
            1: v[j] = box_hi[c][b][j];
            default: v[j] = coord_t'(64'(box_lo[c][b][j]) + ({$urandom, $urandom} % span));
          endcase
        end
        if ($urandom_range(0, 9) == 0) begin
          b = $urandom_range(0, NDIM - 1);
          if (v[b] != 32'sh7fffffff) v[b] = v[b] + 1;
        end
      end
      w = '0;
      send(op, c, bad, v, 0, w);
    end
    start <= 1'b0;

    waited = 0;
    while (verdict_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    $display("Covered %0d tests and %0d trains over %0d checks; %0d faults seen, %0d merges.",
             n_test, n_train, NCHK, n_fault, n_merge);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
